FILE: sv/prrd_pkg.sv
package prrd_pkg;

	// widest level and slot index over the legal parameter range
	localparam int LEVEL_IDX_W = 3;
	localparam int SLOT_IDX_W  = 4;

	typedef enum logic {
		CMD_LOAD     = 1'b0,
		CMD_DISPATCH = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_LOADED     = 2'd0,
		ST_REJECTED   = 2'd1,
		ST_DISPATCHED = 2'd2,
		ST_IDLE       = 2'd3
	} status_t;

	localparam logic [7:0] QUANTUM_RESET = 8'd2;

	typedef struct packed {
		cmd_t        command;
		logic [1:0]  level;
		logic [15:0] burst_time;
	} cmd_item_t;

	typedef struct packed {
		status_t     status;
		logic [1:0]  served_level;
		logic [1:0]  served_slot;
		logic [7:0]  run_time;
		logic [15:0] remaining_after;
		logic        finished;
	} rsp_item_t;

	typedef struct packed {
		logic                   hit;
		logic [LEVEL_IDX_W-1:0] level;
		logic [SLOT_IDX_W-1:0]  slot;
	} pick_t;

endpackage

FILE: sv/prrd_chan_if.sv
interface prrd_chan_if #(parameter type item_t = logic) ();
	logic  valid;
	logic  ready;
	item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: sv/prrd_pick.sv
module prrd_pick #(
	parameter int LEVELS = 4,
	parameter int SLOTS_PER_LEVEL = 4,
	localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1,
	localparam int SLOT_W = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1
) (
	input  logic [LEVELS-1:0][SLOTS_PER_LEVEL-1:0] active,
	input  logic [SLOT_W-1:0]                      ptr [LEVELS],
	output prrd_pkg::pick_t                        pick
);

	localparam int LIW = prrd_pkg::LEVEL_IDX_W;
	localparam int SIW = prrd_pkg::SLOT_IDX_W;

	logic [LVL_W-1:0]           lvl;
	logic                       lvl_hit;
	logic [SLOTS_PER_LEVEL-1:0] row;
	logic [SLOT_W-1:0]          start;
	logic [SLOT_W:0]            sum;

	always_comb begin
		lvl_hit = 1'b0;
		lvl     = '0;
		// scan from the bottom so the highest priority level wins
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (|active[l]) begin
				lvl_hit = 1'b1;
				lvl     = LVL_W'(l);
			end
		end

		row   = active[lvl];
		start = ptr[lvl];

		pick       = '0;
		pick.hit   = lvl_hit;
		pick.level = LIW'(lvl);
		sum        = '0;
		// round robin from the pointer; nearest active slot assigned last
		for (int k = SLOTS_PER_LEVEL - 1; k >= 0; k--) begin
			sum = (SLOT_W+1)'(start) + (SLOT_W+1)'(k);
			if (sum >= (SLOT_W+1)'(SLOTS_PER_LEVEL))
				sum = sum - (SLOT_W+1)'(SLOTS_PER_LEVEL);
			if (row[sum[SLOT_W-1:0]])
				pick.slot = SIW'(sum[SLOT_W-1:0]);
		end
	end

endmodule

FILE: sv/priority_round_robin_dispatcher_core.sv
// channel  role    beat contents
// cmd      sink    command, level, burst_time
// rsp      source  status, served_level, served_slot, run_time, remaining_after, finished
// cfg      sink    quantum (8 bits), always ready
//
// one command per clock sustained while rsp is ready; a result passes through the input
// register, then the result register. the task table is read, the pick is made and
// the table is updated between those registers.
// reset clears the task table, fill counts and pointers, and sets quantum to 2.
// a stalled rsp holds the result register; cmd keeps accepting while the input
// register is empty or moving on.
module priority_round_robin_dispatcher_core #(
	parameter int LEVELS = 4,
	parameter int SLOTS_PER_LEVEL = 4,
	parameter int TIME_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	prrd_chan_if.sink    cmd,
	prrd_chan_if.source  rsp,
	prrd_chan_if.sink    cfg
);

	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SLOT_W = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
	localparam int CNT_W  = $clog2(SLOTS_PER_LEVEL + 1);
	localparam int CMP_W  = (TIME_BITS > 8) ? TIME_BITS : 8;
	localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;

	// task table
	logic [TIME_BITS-1:0] rem_q [LEVELS][SLOTS_PER_LEVEL];
	logic [CNT_W-1:0]     used_q [LEVELS];
	logic [SLOT_W-1:0]    ptr_q [LEVELS];
	logic [7:0]           quantum_q;

	// input and result registers
	logic                 valid_s1;
	prrd_pkg::cmd_item_t  item_s1;
	logic                 res_valid_q;
	prrd_pkg::rsp_item_t  res_q;

	logic                 advance;
	logic [LEVELS-1:0][SLOTS_PER_LEVEL-1:0] active;
	prrd_pkg::pick_t      pick;

	logic [LVL_W-1:0]     lidx;
	logic [CNT_W-1:0]     used_l;
	logic                 level_ok;
	logic                 load_ok;
	logic [TIME_BITS-1:0] burst_sat;

	logic [LVL_W-1:0]     pl;
	logic [SLOT_W-1:0]    ps;
	logic [SLOT_W-1:0]    ps_next;
	logic [7:0]           q_eff;
	logic [CMP_W-1:0]     cur_w;
	logic [CMP_W-1:0]     run_w;
	logic [TIME_BITS-1:0] rem_new;
	logic                 level_left;
	prrd_pkg::rsp_item_t  res_d;

	assign advance   = valid_s1 && (!res_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;
	assign rsp.valid = res_valid_q;
	assign rsp.item  = res_q;

	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			for (int s = 0; s < SLOTS_PER_LEVEL; s++) begin
				active[l][s] = (CNT_W'(s) < used_q[l]) && (rem_q[l][s] != '0);
			end
		end
	end

	prrd_pick #(
		.LEVELS(LEVELS),
		.SLOTS_PER_LEVEL(SLOTS_PER_LEVEL)
	) u_pick (
		.active(active),
		.ptr(ptr_q),
		.pick(pick)
	);

	// load path
	assign lidx     = LVL_W'(item_s1.level);
	assign level_ok = 32'(item_s1.level) < LEVELS;
	assign used_l   = used_q[lidx];
	assign burst_sat = (64'(item_s1.burst_time) > TIME_MAX) ? '1
		: TIME_BITS'(item_s1.burst_time);
	assign load_ok  = (item_s1.burst_time != '0) && level_ok
		&& (32'(used_l) < SLOTS_PER_LEVEL);

	// dispatch path
	assign pl      = pick.level[LVL_W-1:0];
	assign ps      = pick.slot[SLOT_W-1:0];
	assign ps_next = (32'(ps) == SLOTS_PER_LEVEL - 1) ? '0 : ps + SLOT_W'(1);
	assign q_eff   = (quantum_q == '0) ? 8'd1 : quantum_q;
	assign cur_w   = CMP_W'(rem_q[pl][ps]);
	assign run_w   = (cur_w < CMP_W'(q_eff)) ? cur_w : CMP_W'(q_eff);
	assign rem_new = TIME_BITS'(cur_w - run_w);
	assign level_left = (|(active[pl] & ~(SLOTS_PER_LEVEL'(1) << ps))) || (rem_new != '0);

	always_comb begin
		res_d = '0;
		if (item_s1.command == prrd_pkg::CMD_LOAD) begin
			res_d.served_level = item_s1.level;
			if (load_ok) begin
				res_d.status          = prrd_pkg::ST_LOADED;
				res_d.served_slot     = 2'(used_l);
				res_d.remaining_after = 16'(burst_sat);
			end else begin
				res_d.status = prrd_pkg::ST_REJECTED;
			end
		end else if (pick.hit) begin
			res_d.status          = prrd_pkg::ST_DISPATCHED;
			res_d.served_level    = 2'(pl);
			res_d.served_slot     = 2'(ps);
			res_d.run_time        = run_w[7:0];
			res_d.remaining_after = 16'(rem_new);
			res_d.finished        = (rem_new == '0);
		end else begin
			res_d.status = prrd_pkg::ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= prrd_pkg::QUANTUM_RESET;
		end else if (cfg.valid) begin
			quantum_q <= cfg.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready)
			item_s1 <= cmd.item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				used_q[l] <= '0;
				ptr_q[l]  <= '0;
				for (int s = 0; s < SLOTS_PER_LEVEL; s++)
					rem_q[l][s] <= '0;
			end
		end else if (advance) begin
			if (item_s1.command == prrd_pkg::CMD_LOAD) begin
				if (load_ok) begin
					rem_q[lidx][used_l[SLOT_W-1:0]] <= burst_sat;
					used_q[lidx] <= used_l + CNT_W'(1);
				end
			end else if (pick.hit) begin
				rem_q[pl][ps] <= rem_new;
				if (level_left) begin
					ptr_q[pl] <= ps_next;
				end else begin
					// level drained: reopen it for loads
					used_q[pl] <= '0;
					ptr_q[pl]  <= '0;
				end
			end
		end
	end

	// a finished task reports a dispatch that leaves nothing behind
	a_finished_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.finished |->
			res_q.status == prrd_pkg::ST_DISPATCHED && res_q.remaining_after == '0)
		else $error("finished result with time left");

	// every dispatch grants at least one unit
	a_dispatch_progress: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == prrd_pkg::ST_DISPATCHED |-> res_q.run_time != '0)
		else $error("dispatch granted no time");

	// a processed command always lands in the result register
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result lost after advance");

	// fill counts stay within the level
	for (genvar g = 0; g < LEVELS; g++) begin : g_used_chk
		a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
			32'(used_q[g]) <= SLOTS_PER_LEVEL)
			else $error("slot count beyond level size");
	end

endmodule

FILE: test/priority_round_robin_dispatcher_core_test.sv
module priority_round_robin_dispatcher_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum {ROW_CMD, ROW_QUANTUM} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		prrd_pkg::cmd_item_t item;
		bit                  typed;
		prrd_pkg::rsp_item_t want;
		logic [7:0]          quantum;
	} plan_row_t;

	logic clk;
	logic arst_n;

	prrd_chan_if #(.item_t(prrd_pkg::cmd_item_t)) cmd_ch ();
	prrd_chan_if #(.item_t(prrd_pkg::rsp_item_t)) rsp_ch ();
	prrd_chan_if #(.item_t(logic [7:0]))          cfg_ch ();

	priority_round_robin_dispatcher_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// scheduler state as the testbench sees it
	bit [15:0] task_time [4][4];
	bit [2:0]  slots_filled [4];
	bit [1:0]  resume_slot [4];
	bit [7:0]  quantum_q;

	prrd_pkg::rsp_item_t pending_rsp [$];
	plan_row_t           plan [$];
	int                  mismatches;
	bit                  calm;

	always #4 clk = ~clk;

	function automatic bit level_busy(int l);
		for (int s = 0; s < 4; s++) begin
			if (s < slots_filled[l] && task_time[l][s] != 0) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit table_busy();
		for (int l = 0; l < 4; l++) begin
			if (level_busy(l)) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic prrd_pkg::rsp_item_t schedule_step(prrd_pkg::cmd_item_t it);
		prrd_pkg::rsp_item_t r;
		bit [7:0]  slice;
		bit [7:0]  grant;
		bit [2:0]  s;
		bit [1:0]  ps;
		r = '0;
		if (it.command == prrd_pkg::CMD_LOAD) begin
			r.served_level = it.level;
			if (it.burst_time == 0 || slots_filled[it.level] >= 4) begin
				r.status = prrd_pkg::ST_REJECTED;
				return r;
			end
			s = slots_filled[it.level];
			task_time[it.level][s[1:0]] = it.burst_time;
			slots_filled[it.level] = s + 3'd1;
			r.status = prrd_pkg::ST_LOADED;
			r.served_slot = s[1:0];
			r.remaining_after = it.burst_time;
			return r;
		end
		// a zero slice would never make progress
		slice = (quantum_q == 0) ? 8'd1 : quantum_q;
		for (int l = 0; l < 4; l++) begin
			if (!level_busy(l)) continue;
			for (int k = 0; k < 4; k++) begin
				ps = 2'(resume_slot[l] + k);
				if (ps >= slots_filled[l] || task_time[l][ps] == 0) continue;
				grant = (task_time[l][ps] < {8'd0, slice}) ? task_time[l][ps][7:0] : slice;
				task_time[l][ps] = task_time[l][ps] - {8'd0, grant};
				resume_slot[l] = ps + 2'd1;
				r.status = prrd_pkg::ST_DISPATCHED;
				r.served_level = 2'(l);
				r.served_slot = ps;
				r.run_time = grant;
				r.remaining_after = task_time[l][ps];
				r.finished = (task_time[l][ps] == 0);
				// drained level takes loads from slot 0 again
				if (!level_busy(l)) begin
					slots_filled[l] = '0;
					resume_slot[l] = '0;
				end
				return r;
			end
		end
		r.status = prrd_pkg::ST_IDLE;
		return r;
	endfunction

	function automatic prrd_pkg::rsp_item_t typed_rsp(prrd_pkg::status_t st, logic [1:0] lvl,
			logic [1:0] slot, logic [15:0] rem);
		prrd_pkg::rsp_item_t r;
		r = '0;
		r.status = st;
		r.served_level = lvl;
		r.served_slot = slot;
		r.remaining_after = rem;
		return r;
	endfunction

	function automatic void add_row(row_kind_t k, prrd_pkg::cmd_t c, logic [1:0] lvl,
			logic [15:0] b, bit typed, prrd_pkg::rsp_item_t want);
		plan_row_t row;
		row.kind = k;
		row.item.command = c;
		row.item.level = lvl;
		row.item.burst_time = b;
		row.typed = typed;
		row.want = want;
		row.quantum = b[7:0];
		plan.push_back(row);
	endfunction

	// call right after a rising edge
	task automatic send_cmd(input prrd_pkg::cmd_item_t it, input bit typed,
			input prrd_pkg::rsp_item_t want);
		prrd_pkg::rsp_item_t predicted;
		while (!calm && $urandom_range(99) < 19) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.item <= it;
		@(negedge clk);
		while (!cmd_ch.ready) @(negedge clk);
		@(posedge clk);
		predicted = schedule_step(it);
		pending_rsp.push_back(typed ? want : predicted);
	endtask

	task automatic write_quantum(input logic [7:0] q);
		cmd_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.item <= q;
		@(negedge clk);
		while (!cfg_ch.ready) @(negedge clk);
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
		quantum_q = q;
		@(posedge clk);
	endtask

	task automatic drain_table();
		prrd_pkg::cmd_item_t it;
		while (table_busy()) begin
			it.command = prrd_pkg::CMD_DISPATCH;
			it.level = 2'($urandom);
			it.burst_time = 16'($urandom);
			send_cmd(it, 1'b0, '0);
		end
	endtask

	// response side stalls at random unless in a calm stretch
	always @(posedge clk) begin
		rsp_ch.ready <= calm || ($urandom_range(99) >= 19);
	end

	// values are stable between the falling edge and the accepting rising edge
	always @(negedge clk) begin : check_rsp
		prrd_pkg::rsp_item_t want;
		prrd_pkg::rsp_item_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.item;
			if (pending_rsp.size() == 0) begin
				$error("result beat with nothing expected: %p", got);
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatches++;
				end
				if (got.served_level !== want.served_level) begin
					$error("served_level: expected %0d, got %0d", want.served_level,
						got.served_level);
					mismatches++;
				end
				if (got.served_slot !== want.served_slot) begin
					$error("served_slot: expected %0d, got %0d", want.served_slot,
						got.served_slot);
					mismatches++;
				end
				if (got.run_time !== want.run_time) begin
					$error("run_time: expected %0d, got %0d", want.run_time, got.run_time);
					mismatches++;
				end
				if (got.remaining_after !== want.remaining_after) begin
					$error("remaining_after: expected %0d, got %0d", want.remaining_after,
						got.remaining_after);
					mismatches++;
				end
				if (got.finished !== want.finished) begin
					$error("finished: expected %0d, got %0d", want.finished, got.finished);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#8ms;
		$display("priority_round_robin_dispatcher_core_test: FAIL");
		$finish;
	end

	initial begin
		prrd_pkg::cmd_item_t it;
		logic [7:0] phase_q [6];
		int         load_pct;
		int         pick;
		bit         wide;
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.item = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.item = '0;
		rsp_ch.ready = 1'b0;
		mismatches = 0;
		calm = 1'b0;
		quantum_q = prrd_pkg::QUANTUM_RESET;

		// directed part, starts at the reset slice of 2
		add_row(ROW_CMD, prrd_pkg::CMD_DISPATCH, 2'd0, 16'd0, 1'b1,
			typed_rsp(prrd_pkg::ST_IDLE, 2'd0, 2'd0, 16'd0));
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd0, 16'd0, 1'b1,
			typed_rsp(prrd_pkg::ST_REJECTED, 2'd0, 2'd0, 16'd0));
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd3, 16'd5, 1'b1,
			typed_rsp(prrd_pkg::ST_LOADED, 2'd3, 2'd0, 16'd5));
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd3, 16'd1, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd3, 16'd2, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd3, 16'd3, 1'b0, '0);
		// level full
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd3, 16'd9, 1'b1,
			typed_rsp(prrd_pkg::ST_REJECTED, 2'd3, 2'd0, 16'd0));
		add_row(ROW_CMD, prrd_pkg::CMD_DISPATCH, 2'd3, 16'hFFFF, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd1, 16'd1, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_DISPATCH, 2'd0, 16'd0, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_DISPATCH, 2'd0, 16'd0, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_DISPATCH, 2'd2, 16'd7, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd2, 16'd0, 1'b1,
			typed_rsp(prrd_pkg::ST_REJECTED, 2'd2, 2'd0, 16'd0));
		add_row(ROW_QUANTUM, prrd_pkg::CMD_LOAD, 2'd0, 16'd0, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd2, 16'd3, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_DISPATCH, 2'd0, 16'd0, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_DISPATCH, 2'd1, 16'd0, 1'b0, '0);
		add_row(ROW_QUANTUM, prrd_pkg::CMD_LOAD, 2'd0, 16'd255, 1'b0, '0);
		// level 1 was drained earlier, so slot 0 is free again
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd1, 16'hFFFF, 1'b1,
			typed_rsp(prrd_pkg::ST_LOADED, 2'd1, 2'd0, 16'hFFFF));
		add_row(ROW_CMD, prrd_pkg::CMD_LOAD, 2'd0, 16'h00FF, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_DISPATCH, 2'd0, 16'd0, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_DISPATCH, 2'd0, 16'd0, 1'b0, '0);
		add_row(ROW_CMD, prrd_pkg::CMD_DISPATCH, 2'd0, 16'd0, 1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_QUANTUM)
				write_quantum(plan[i].quantum);
			else
				send_cmd(plan[i].item, plan[i].typed, plan[i].want);
		end
		drain_table();

		phase_q[0] = 8'd1;
		phase_q[1] = 8'($urandom_range(3, 16));
		phase_q[2] = 8'd0;
		phase_q[3] = 8'd255;
		phase_q[4] = 8'($urandom_range(128, 254));
		phase_q[5] = 8'($urandom_range(1, 255));

		foreach (phase_q[p]) begin
			write_quantum(phase_q[p]);
			calm = (p == 1);
			load_pct = $urandom_range(30, 60);
			// long tasks only where the slice is big enough to retire them
			wide = (quantum_q >= 8'd128);
			for (int n = 0; n < 220; n++) begin
				it.command = ($urandom_range(99) < load_pct) ? prrd_pkg::CMD_LOAD
					: prrd_pkg::CMD_DISPATCH;
				it.level = 2'($urandom);
				pick = $urandom_range(99);
				if (pick < 5)
					it.burst_time = '0;
				else if (wide && pick < 7)
					it.burst_time = 16'hFFFF;
				else if (wide && pick < 12)
					it.burst_time = 16'($urandom_range(13, 4095));
				else
					it.burst_time = 16'($urandom_range(1, 12));
				send_cmd(it, 1'b0, '0);
			end
			drain_table();
		end
		calm = 1'b0;

		cmd_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("priority_round_robin_dispatcher_core_test: PASS");
		else
			$display("priority_round_robin_dispatcher_core_test: FAIL");
		$finish;
	end

endmodule
